FILE: rtl/core/base58_encoder_top_macros.svh
// Assertion macros for the base58 encoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BASE58_ENCODER_TOP_MACROS_SVH
`define BASE58_ENCODER_TOP_MACROS_SVH

// Plain property, clocked on clk and off during reset.
`define B58_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Overlapping implication, clocked on clk and off during reset.
`define B58_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/b58enc_pkg.sv
// Shared types, codes and constant tables for the base58 encoder.
// No dependencies; imported by the controller, the datapath and the top level.
package b58enc_pkg;

	localparam int RADIX = 58;
	localparam int BUF_W = 9;
	localparam int BYTE_W = 8;
	localparam int DIG_W = 6;
	localparam int CHAR_W = 7;
	localparam int STAT_W = 2;
	localparam int TAB_N = 64;

	localparam logic [BUF_W-1:0] BUF_LIMIT_RST = 9'd128;

	// request kinds
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_LONG  = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	// character source of a pending read
	localparam logic [1:0] CH_NONE  = 2'd0;
	localparam logic [1:0] CH_ONE   = 2'd1;
	localparam logic [1:0] CH_DIGIT = 2'd2;

	// ASCII '1', emitted once per leading zero byte
	localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

	localparam logic [8*RADIX-1:0] ALPHA_STR =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	typedef logic [CHAR_W-1:0] alpha_t [TAB_N];
	// {quotient, remainder} of 256*d by 58
	typedef logic [BYTE_W+DIG_W-1:0] divtab_t [TAB_N];

	typedef struct packed {
		logic accept;
		logic fold_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fold_need;
		logic fold_last;
		logic out_free;
	} dp_stat_t;

	function automatic alpha_t build_alpha();
		alpha_t tab;
		int k;
		for (int i = 0; i < TAB_N; i++) begin
			k = i % RADIX;
			tab[i] = ALPHA_STR[8*(RADIX-1-k) +: CHAR_W];
		end
		return tab;
	endfunction

	function automatic divtab_t build_divtab();
		divtab_t tab;
		int k;
		for (int i = 0; i < TAB_N; i++) begin
			k = i % RADIX;
			tab[i] = {BYTE_W'((256*k) / RADIX), DIG_W'((256*k) % RADIX)};
		end
		return tab;
	endfunction

	localparam alpha_t ALPHA_TAB = build_alpha();
	localparam divtab_t DIV_TAB = build_divtab();

endpackage

FILE: rtl/core/b58enc_ctrl.sv
// Controller state machine of the base58 encoder.
// Depends on b58enc_pkg; drives commands into b58enc_dp and reads its status.
module b58enc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_type,
	input  b58enc_pkg::dp_stat_t  stat,
	output b58enc_pkg::ctrl_cmd_t cmd,
	output logic                  req_stall
);
	import b58enc_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FOLD  = 2'd1;
	localparam logic [1:0] S_RDOUT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (req_type == REQ_READ) begin
						state_n = S_RDOUT;
					end else if (stat.fold_need) begin
						state_n = S_FOLD;
					end
				end
			end
			S_FOLD: begin
				cmd.fold_step = 1'b1;
				if (stat.fold_last) begin
					state_n = S_IDLE;
				end
			end
			S_RDOUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

FILE: rtl/core/b58enc_dp.sv
// Datapath of the base58 encoder: digit memory, carry unit, counters, result register.
// Depends on b58enc_pkg and base58_encoder_top_macros.svh; driven by b58enc_ctrl.
`include "base58_encoder_top_macros.svh"

module b58enc_dp #(
	parameter int MAX_BYTES   = 64,
	parameter int DIGIT_DEPTH = 89
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  b58enc_pkg::ctrl_cmd_t                 cmd,
	output b58enc_pkg::dp_stat_t                  stat,
	input  logic                                  req_type,
	input  logic [b58enc_pkg::BYTE_W-1:0]         byte_value,
	input  logic                                  first,
	input  logic                                  cfg_we,
	input  logic [b58enc_pkg::BUF_W-1:0]          cfg_data,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic [b58enc_pkg::CHAR_W-1:0]         char_code,
	output logic                                  last,
	output logic [b58enc_pkg::STAT_W-1:0]         status
);
	import b58enc_pkg::*;

	localparam int IW   = $clog2(DIGIT_DEPTH);
	localparam int UW   = $clog2(DIGIT_DEPTH + 1);
	localparam int CW   = $clog2(MAX_BYTES + 1);
	localparam int TW   = $clog2(MAX_BYTES + DIGIT_DEPTH + 1);
	localparam int CMPW = (TW > BUF_W) ? TW : BUF_W;
	localparam int CRW  = 9;  // carry stays at or below 256
	localparam int XW   = 9;  // remainder plus carry stays below 314

	// digit memory and per-entry valid bits
	logic [DIG_W-1:0]       mem [DIGIT_DEPTH];
	logic [DIGIT_DEPTH-1:0] vld_q;
	logic [DIG_W-1:0]       rd_data_q;
	logic                   rd_vld_q;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;

	// number state
	logic [BUF_W-1:0] buf_lim_q;
	logic [CW-1:0]    zc_q;
	logic [CW-1:0]    bc_q;
	logic             seen_q;
	logic [UW-1:0]    used_q;
	logic [TW-1:0]    rp_q;
	logic             ovf_q;

	// fold sweep
	logic [IW-1:0]  wr_idx_q;
	logic [CRW-1:0] carry_q;

	// pending read
	logic [1:0]        rsel_q;
	logic              rlast_q;
	logic [STAT_W-1:0] rstat_q;

	// result register
	logic              res_valid_q;
	logic [CHAR_W-1:0] res_char_q;
	logic              res_last_q;
	logic [STAT_W-1:0] res_stat_q;

	logic             push_acc;
	logic             read_acc;
	logic [CW-1:0]    eff_bc;
	logic [CW-1:0]    eff_zc;
	logic             eff_seen;
	logic             full;
	logic             lead_zero;
	logic [TW-1:0]    total;
	logic             err_long;
	logic             empty;
	logic             lead_pos;
	logic             rd_ok;
	logic [IW-1:0]    di;
	logic [DIG_W-1:0] dig;
	logic [BYTE_W+DIG_W-1:0] tab_ent;
	logic [XW-1:0]    x;
	logic [2:0]       q2;
	logic [XW-1:0]    r_full;
	logic [DIG_W-1:0] r_dig;
	logic [CRW-1:0]   carry_n;
	logic [CHAR_W-1:0] char_n;

	assign push_acc = cmd.accept && (req_type == REQ_PUSH);
	assign read_acc = cmd.accept && (req_type == REQ_READ);

	// push decode, with first taken as a clear ahead of the byte
	assign eff_bc    = first ? '0 : bc_q;
	assign eff_zc    = first ? '0 : zc_q;
	assign eff_seen  = first ? 1'b0 : seen_q;
	assign full      = (eff_bc >= CW'(MAX_BYTES));
	assign lead_zero = !eff_seen && (byte_value == '0);

	// read decode
	assign total    = TW'(zc_q) + TW'(used_q);
	assign err_long = (CMPW'(total) >= CMPW'(buf_lim_q));
	assign empty    = (rp_q >= total);
	assign lead_pos = (rp_q < TW'(zc_q));
	assign rd_ok    = !err_long && !empty;
	assign di       = IW'(TW'(used_q) - TW'(1) - (rp_q - TW'(zc_q)));

	// one carry step: d*256 + carry, split by 58 via table and small compare chain
	assign dig     = rd_vld_q ? rd_data_q : '0;
	assign tab_ent = DIV_TAB[dig];
	assign x       = XW'(tab_ent[DIG_W-1:0]) + XW'(carry_q);

	always_comb begin
		q2 = '0;
		for (int k = 1; k <= 5; k++) begin
			if (x >= XW'(k * RADIX)) begin
				q2 = 3'(k);
			end
		end
	end

	assign r_full  = x - XW'(q2) * XW'(RADIX);
	assign r_dig   = r_full[DIG_W-1:0];
	assign carry_n = CRW'(tab_ent[BYTE_W+DIG_W-1:DIG_W]) + CRW'(q2);

	// memory port
	assign rd_en   = cmd.accept || cmd.fold_step;
	assign rd_addr = cmd.fold_step ? (stat.fold_last ? '0 : wr_idx_q + IW'(1)) :
		((req_type == REQ_READ) ? di : '0);

	always_ff @(posedge clk) begin
		if (cmd.fold_step) begin
			mem[wr_idx_q] <= r_dig;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (push_acc) begin
			carry_q <= CRW'(byte_value);
		end else if (cmd.fold_step) begin
			carry_q <= carry_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			wr_idx_q <= '0;
		end else begin
			if (push_acc && first) begin
				vld_q <= '0;
			end else if (cmd.fold_step) begin
				vld_q[wr_idx_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr] && !(push_acc && first);
			end
			if (push_acc) begin
				wr_idx_q <= '0;
			end else if (cmd.fold_step) begin
				wr_idx_q <= wr_idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_lim_q <= BUF_LIMIT_RST;
			zc_q      <= '0;
			bc_q      <= '0;
			seen_q    <= 1'b0;
			used_q    <= '0;
			rp_q      <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				buf_lim_q <= cfg_data;
			end
			if (push_acc) begin
				if (first) begin
					zc_q   <= '0;
					bc_q   <= '0;
					seen_q <= 1'b0;
					used_q <= '0;
					rp_q   <= '0;
					ovf_q  <= 1'b0;
				end
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					bc_q <= eff_bc + CW'(1);
					if (lead_zero) begin
						zc_q <= eff_zc + CW'(1);
					end else begin
						seen_q <= 1'b1;
						used_q <= '0;
					end
				end
			end
			if (read_acc && rd_ok) begin
				rp_q <= rp_q + TW'(1);
			end
			if (cmd.fold_step && (r_dig != '0)) begin
				used_q <= UW'(wr_idx_q) + UW'(1);
			end
		end
	end

	// classify the read at accept; the digit arrives from memory in the following cycle
	always_ff @(posedge clk) begin
		if (read_acc) begin
			if (err_long) begin
				rsel_q  <= CH_NONE;
				rlast_q <= 1'b1;
				rstat_q <= ST_LONG;
			end else if (empty) begin
				rsel_q  <= CH_NONE;
				rlast_q <= 1'b0;
				rstat_q <= ST_EMPTY;
			end else begin
				rsel_q  <= lead_pos ? CH_ONE : CH_DIGIT;
				rlast_q <= ((rp_q + TW'(1)) == total);
				rstat_q <= ovf_q ? ST_OVF : ST_OK;
			end
		end
	end

	always_comb begin
		case (rsel_q)
			CH_ONE:   char_n = CHAR_ONE;
			CH_DIGIT: char_n = ALPHA_TAB[dig];
			default:  char_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_char_q <= char_n;
			res_last_q <= rlast_q;
			res_stat_q <= rstat_q;
		end
	end

	assign stat.fold_need = (req_type == REQ_PUSH) && !full && !lead_zero;
	assign stat.fold_last = (wr_idx_q == IW'(DIGIT_DEPTH - 1));
	assign stat.out_free  = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign char_code = res_char_q;
	assign last      = res_last_q;
	assign status    = res_stat_q;

	`B58_ASSERT_IMP(a_load_free, cmd.load_out, !res_valid_q || !res_stall, "result overwritten while stalled")
	`B58_ASSERT(a_used_range, used_q <= UW'(DIGIT_DEPTH), "used digit count beyond store depth")
	`B58_ASSERT_IMP(a_rp_step, rp_q != $past(rp_q), rp_q == $past(rp_q) + TW'(1) || rp_q == '0, "read position jumped")
	`B58_ASSERT_IMP(a_fold_excl, cmd.fold_step, !cmd.accept && !cmd.load_out, "fold step overlaps other command")

endmodule

FILE: rtl/core/base58_encoder_top.sv
// Sequence: a push that folds a byte sweeps the whole digit store, stalling the request side
//   until the sweep ends; a leading zero byte or an ignored push leaves the request side free;
//   a read stalls the request side until the result register is free, then loads it.
// Throughput: one digit of the store per cycle through the single carry unit; the request
//   side takes no new push or read until the current one is done.
// Reset: arst_n clears all control, the digit valid bits and counters; buf_limit -> 128.
module base58_encoder_top #(
	parameter int MAX_BYTES   = 64,
	parameter int DIGIT_DEPTH = 89
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          req_type,
	input  logic [b58enc_pkg::BYTE_W-1:0] byte_value,
	input  logic                          first,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [b58enc_pkg::CHAR_W-1:0] char_code,
	output logic                          last,
	output logic [b58enc_pkg::STAT_W-1:0] status,
	// buf_limit write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [b58enc_pkg::BUF_W-1:0]  buf_limit
);
	import b58enc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The write goes straight into the buf_limit register; the port never pushes back.
	assign cfg_ready = 1'b1;

	// Sequencer: idle accepts an item, a folding push sweeps the digit store
	// one entry per cycle, a read waits for the result register to free up.
	b58enc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	// Datapath: digit memory with valid bits (cleared at once by first),
	// carry unit, counters, read classification and the result register.
	b58enc_dp #(
		.MAX_BYTES   (MAX_BYTES),
		.DIGIT_DEPTH (DIGIT_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.byte_value (byte_value),
		.first      (first),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (buf_limit),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.char_code  (char_code),
		.last       (last),
		.status     (status)
	);

endmodule
